/* src/tcm_pkg.sv */
// shared types, constants and the coefficient table for the turbo colormap pipeline
// no dependencies; used by tcm_channel and turbo_colormap_pixel_top
`default_nettype none

package tcm_pkg;

    localparam int PIX_W     = 16;
    localparam int XQ_W      = 16;
    localparam int SEC_W     = 3;
    localparam int DEPTH_W   = 5;
    localparam int SHIFT_W   = 4;
    localparam int COLOR_W   = 8;
    localparam int CHAN_W    = 2;
    localparam int A_W       = 32;
    localparam int B_W       = 25;
    localparam int C_W       = 18;
    localparam int BX_W      = B_W + XQ_W + 1;
    localparam int XX_W      = 2 * XQ_W;
    localparam int CXX_W     = C_W + XX_W + 1;
    localparam int ACC_W     = 54;
    localparam int FRAC_BITS = 36;

    localparam logic [XQ_W-1:0]    XQ_CAP     = 16'hFF00;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN  = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_RST  = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 4'd8;
    localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;

    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [C_W-1:0] c;
    } t_coef;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    function automatic t_coef mk_coef(input int a, input int b, input int c);
        t_coef r;
        r.a = A_W'(a);
        r.b = B_W'(b);
        r.c = C_W'(c);
        return r;
    endfunction

    // signed coefficients per channel and sector: a in q12.20, b in q13.12, c in q14.4
    function automatic t_coef coef_lookup(input logic [CHAN_W-1:0] chan,
                                          input logic [SEC_W-1:0] sec);
        t_coef r;
        r = '0;
        case (chan)
            CH_RED: begin
                case (sec)
                    3'd0:    r = mk_coef(50990925, 1326385, 18820);
                    3'd1:    r = mk_coef(13527889, 3330267, -45317);
                    3'd2:    r = mk_coef(577488552, -14040957, 89215);
                    3'd3:    r = mk_coef(-395349852, 5196376, -5734);
                    3'd4:    r = mk_coef(-484088742, 7253682, -16611);
                    3'd5:    r = mk_coef(-948116128, 13401326, -36928);
                    3'd6:    r = mk_coef(-417139261, 7794233, -22115);
                    default: r = mk_coef(-538700677, 8914007, -24692);
                endcase
            end
            CH_GREEN: begin
                case (sec)
                    3'd0:    r = mk_coef(19262236, 3129318, -6193);
                    3'd1:    r = mk_coef(26774235, 2727503, -879);
                    3'd2:    r = mk_coef(-69193957, 5748745, -24763);
                    3'd3:    r = mk_coef(-95332755, 6109444, -25674);
                    3'd4:    r = mk_coef(-49450005, 5653146, -24904);
                    3'd5:    r = mk_coef(-69116887, 5523468, -23318);
                    3'd6:    r = mk_coef(1728902595, -13221914, 25564);
                    default: r = mk_coef(1216568361, -8502420, 14699);
                endcase
            end
            CH_BLUE: begin
                case (sec)
                    3'd0:    r = mk_coef(62322219, 7945910, -75540);
                    3'd1:    r = mk_coef(30858333, 9629031, -97799);
                    3'd2:    r = mk_coef(410711491, -2429131, -1746);
                    3'd3:    r = mk_coef(807477969, -9417240, 27973);
                    3'd4:    r = mk_coef(635935130, -8126946, 28413);
                    3'd5:    r = mk_coef(-669136191, 9110479, -28397);
                    3'd6:    r = mk_coef(1066863165, -9188231, 19859);
                    default: r = mk_coef(655548744, -5399286, 11136);
                endcase
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/tcm_channel.sv */
// one color channel: coefficient lookup, quadratic evaluation and clamp, four stages
// depends on tcm_pkg; stage enables come from turbo_colormap_pixel_top
`default_nettype none

module tcm_channel (
    input  wire logic                         i_clk,
    input  wire tcm_pkg::t_stage_en           i_en,
    input  wire logic [tcm_pkg::CHAN_W-1:0]   i_chan,
    input  wire logic [tcm_pkg::XQ_W-1:0]     i_xq,
    input  wire logic [tcm_pkg::SEC_W-1:0]    i_sec,
    output logic      [tcm_pkg::COLOR_W-1:0]  o_color
);

    tcm_pkg::t_coef                       n_coef;
    logic signed [tcm_pkg::BX_W-1:0]      n_bx;
    logic        [tcm_pkg::XX_W-1:0]      n_xx;
    logic signed [tcm_pkg::CXX_W-1:0]     n_cxx;
    logic signed [tcm_pkg::ACC_W-1:0]     n_acc;
    logic        [tcm_pkg::COLOR_W-1:0]   n_color;

    logic signed [tcm_pkg::A_W-1:0]       r_a2;
    logic signed [tcm_pkg::C_W-1:0]       r_c2;
    logic signed [tcm_pkg::BX_W-1:0]      r_bx2;
    logic        [tcm_pkg::XX_W-1:0]      r_xx2;
    logic signed [tcm_pkg::A_W-1:0]       r_a3;
    logic signed [tcm_pkg::BX_W-1:0]      r_bx3;
    logic signed [tcm_pkg::CXX_W-1:0]     r_cxx3;
    logic signed [tcm_pkg::ACC_W-1:0]     r_acc4;
    logic        [tcm_pkg::COLOR_W-1:0]   r_color5;

    // stage 2: table lookup, b*x and x*x
    always_comb begin
        n_coef = tcm_pkg::coef_lookup(i_chan, i_sec);
        n_bx   = n_coef.b * $signed({1'b0, i_xq});
        n_xx   = i_xq * i_xq;
    end

    // stage 3: c*x*x
    assign n_cxx = r_c2 * $signed({1'b0, r_xx2});

    // stage 4: sum in q.36
    assign n_acc = {{(tcm_pkg::ACC_W - tcm_pkg::A_W - 16){r_a3[tcm_pkg::A_W-1]}}, r_a3, 16'h0000}
                 + {{(tcm_pkg::ACC_W - tcm_pkg::BX_W - 8){r_bx3[tcm_pkg::BX_W-1]}}, r_bx3, 8'h00}
                 + {{(tcm_pkg::ACC_W - tcm_pkg::CXX_W){r_cxx3[tcm_pkg::CXX_W-1]}}, r_cxx3};

    // stage 5: truncate and clamp
    always_comb begin
        if (r_acc4[tcm_pkg::ACC_W-1]) begin
            n_color = '0;
        end else if (|r_acc4[tcm_pkg::ACC_W-2:tcm_pkg::FRAC_BITS+tcm_pkg::COLOR_W]) begin
            n_color = tcm_pkg::COLOR_MAX;
        end else begin
            n_color = r_acc4[tcm_pkg::FRAC_BITS+tcm_pkg::COLOR_W-1:tcm_pkg::FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_a2  <= n_coef.a;
            r_c2  <= n_coef.c;
            r_bx2 <= n_bx;
            r_xx2 <= n_xx;
        end
        if (i_en.s3) begin
            r_a3   <= r_a2;
            r_bx3  <= r_bx2;
            r_cxx3 <= n_cxx;
        end
        if (i_en.s4) begin
            r_acc4 <= n_acc;
        end
        if (i_en.s5) begin
            r_color5 <= n_color;
        end
    end

    assign o_color = r_color5;

endmodule

`default_nettype wire

/* src/turbo_colormap_pixel_top.sv */
// top level of the turbo colormap pipeline: depth register, pixel scaling, stall control
// depends on tcm_pkg and tcm_channel
//
//  channel   signals                                       width  role
//  pixel in  i_valid / o_ready / i_pixel                   16     grey pixel
//  color out o_valid / i_ready / o_red, o_green, o_blue    8 x 3  clamped rgb
//  config    i_cfg_valid / o_cfg_ready / i_cfg_sensor_bit_depth  5  bits per pixel
//
//  five register stages: scale and cap, lookup with b*x and x*x, c*x*x, sum, clamp
//  one transaction per cycle while i_ready does not stall the output; each passes all five register stages
//  each stage moves when it is empty or the next one moves, so bubbles are squeezed out
//  the c*x*x multiply has its own stage because it uses the registered x*x
//  reset clears the valid bits and sets the bit depth to 16
`default_nettype none

module turbo_colormap_pixel_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tcm_pkg::DEPTH_W-1:0]     i_cfg_sensor_bit_depth,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [tcm_pkg::PIX_W-1:0]       i_pixel,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [tcm_pkg::COLOR_W-1:0]     o_red,
    output logic      [tcm_pkg::COLOR_W-1:0]     o_green,
    output logic      [tcm_pkg::COLOR_W-1:0]     o_blue
);

    localparam int SCALED_W = tcm_pkg::PIX_W + 8;

    logic [tcm_pkg::SHIFT_W-1:0] r_shift;
    logic [tcm_pkg::SHIFT_W-1:0] n_shift;
    logic [SCALED_W-1:0]         n_scaled;
    logic [tcm_pkg::XQ_W-1:0]    n_xq;
    logic [tcm_pkg::XQ_W-1:0]    r_xq;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic                        r_v4;
    logic                        r_v5;
    logic                        en1;
    tcm_pkg::t_stage_en          stage_en;

    // depth clamped to 8..16 and stored as the downscale shift
    always_comb begin
        if (i_cfg_sensor_bit_depth < tcm_pkg::DEPTH_MIN) begin
            n_shift = '0;
        end else if (i_cfg_sensor_bit_depth > tcm_pkg::DEPTH_MAX) begin
            n_shift = tcm_pkg::SHIFT_MAX;
        end else begin
            n_shift = tcm_pkg::SHIFT_W'(i_cfg_sensor_bit_depth - tcm_pkg::DEPTH_MIN);
        end
    end

    always_comb begin
        n_scaled = {i_pixel, 8'h00} >> r_shift;
        if (n_scaled > SCALED_W'(tcm_pkg::XQ_CAP)) begin
            n_xq = tcm_pkg::XQ_CAP;
        end else begin
            n_xq = n_scaled[tcm_pkg::XQ_W-1:0];
        end
    end

    always_comb begin
        stage_en.s5 = !r_v5 || i_ready;
        stage_en.s4 = !r_v4 || stage_en.s5;
        stage_en.s3 = !r_v3 || stage_en.s4;
        stage_en.s2 = !r_v2 || stage_en.s3;
        en1         = !r_v1 || stage_en.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= tcm_pkg::SHIFT_W'(tcm_pkg::DEPTH_RST - tcm_pkg::DEPTH_MIN);
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_shift <= n_shift;
            end
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (stage_en.s2) begin
                r_v2 <= r_v1;
            end
            if (stage_en.s3) begin
                r_v3 <= r_v2;
            end
            if (stage_en.s4) begin
                r_v4 <= r_v3;
            end
            if (stage_en.s5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_xq <= n_xq;
        end
    end

    tcm_channel u_red (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_chan  (tcm_pkg::CH_RED),
        .i_xq    (r_xq),
        .i_sec   (r_xq[tcm_pkg::XQ_W-1 -: tcm_pkg::SEC_W]),
        .o_color (o_red)
    );

    tcm_channel u_green (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_chan  (tcm_pkg::CH_GREEN),
        .i_xq    (r_xq),
        .i_sec   (r_xq[tcm_pkg::XQ_W-1 -: tcm_pkg::SEC_W]),
        .o_color (o_green)
    );

    tcm_channel u_blue (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_chan  (tcm_pkg::CH_BLUE),
        .i_xq    (r_xq),
        .i_sec   (r_xq[tcm_pkg::XQ_W-1 -: tcm_pkg::SEC_W]),
        .o_color (o_blue)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = en1;
    assign o_valid     = r_v5;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready))
        else $error("input stalled while the pipeline has room");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted transaction lost at stage one");

    a_xq_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_xq <= tcm_pkg::XQ_CAP))
        else $error("scaled pixel above cap");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift <= tcm_pkg::SHIFT_MAX)
        else $error("downscale shift out of range");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !i_ready) |=> (r_v5 && $stable(o_red) && $stable(o_green) && $stable(o_blue)))
        else $error("stalled output changed");

endmodule

`default_nettype wire
